FILE: rtl/kmp_prefix_function_stream_assert.svh
// assertion macros for the kmp prefix function stream rtl
`ifndef KMP_PREFIX_FUNCTION_STREAM_ASSERT_SVH
`define KMP_PREFIX_FUNCTION_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KMPPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KMPPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kmppf_pkg.sv
// shared constants and transaction types for the kmp prefix function stream
package kmppf_pkg;

    localparam int MAX_WORD_LEN = 64;
    localparam int ADDR_W       = $clog2(MAX_WORD_LEN);
    localparam int POS_W        = ADDR_W + 1;
    localparam int SYM_W        = 8;
    localparam int FIELD_W      = 6;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             word_start;
    } sym_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] border_length;
        logic [FIELD_W-1:0] char_position;
        logic               overflow;
    } res_item_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] char_rd_addr;
        logic [ADDR_W-1:0] border_rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SYM_W-1:0]  wr_char;
        logic [ADDR_W-1:0] wr_border;
    } mem_req_t;

endpackage

FILE: rtl/kmppf_ram.sv
// simple dual-port ram with registered read data
module kmppf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kmppf_ctrl.sv
// border walk sequencer: reads the stores, compares, writes back the new entry
`include "kmp_prefix_function_stream_assert.svh"

module kmppf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sym_valid,
    output logic                          sym_stall,
    input  kmppf_pkg::sym_item_t          sym_data,
    output logic                          done_valid,
    input  logic                          done_take,
    output kmppf_pkg::res_item_t          done_item,
    output kmppf_pkg::mem_req_t           mem_req,
    input  logic [kmppf_pkg::SYM_W-1:0]   char_rdata,
    input  logic [kmppf_pkg::ADDR_W-1:0]  border_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [kmppf_pkg::POS_W-1:0] POS_FULL =
        kmppf_pkg::POS_W'(kmppf_pkg::MAX_WORD_LEN);

    logic [1:0]                        state_reg, state_next;
    logic [kmppf_pkg::POS_W-1:0]       wpos_reg, wpos_next;
    logic [kmppf_pkg::ADDR_W-1:0]      last_border_reg, last_border_next;
    logic [kmppf_pkg::SYM_W-1:0]       sym_reg, sym_next;
    logic [kmppf_pkg::ADDR_W-1:0]      p_reg, p_next;
    logic [kmppf_pkg::ADDR_W-1:0]      len_reg, len_next;
    kmppf_pkg::res_item_t              res_reg, res_next;

    logic [kmppf_pkg::POS_W-1:0]       p_in;
    logic                              match;
    logic [kmppf_pkg::ADDR_W-1:0]      fin_len;

    assign p_in    = sym_data.word_start ? '0 : wpos_reg;
    assign match   = (char_rdata == sym_reg);
    assign fin_len = match ? (len_reg + kmppf_pkg::ADDR_W'(1)) : '0;

    assign sym_stall  = (state_reg != S_IDLE);
    assign done_valid = (state_reg == S_DONE);
    assign done_item  = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        wpos_next        = wpos_reg;
        last_border_next = last_border_reg;
        sym_next         = sym_reg;
        p_next           = p_reg;
        len_next         = len_reg;
        res_next         = res_reg;

        mem_req.rd_en          = 1'b0;
        mem_req.char_rd_addr   = len_reg;
        mem_req.border_rd_addr = len_reg - kmppf_pkg::ADDR_W'(1);
        mem_req.wr_en          = 1'b0;
        mem_req.wr_addr        = p_reg;
        mem_req.wr_char        = sym_reg;
        mem_req.wr_border      = fin_len;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sym_valid)
                begin
                    sym_next = sym_data.symbol;
                    p_next   = p_in[kmppf_pkg::ADDR_W-1:0];
                    if (p_in >= POS_FULL)
                    begin
                        // word full: character dropped, stores and write position unchanged
                        res_next.border_length = '0;
                        res_next.char_position = '0;
                        res_next.overflow      = 1'b1;
                        state_next             = S_DONE;
                    end
                    else if (p_in == '0)
                    begin
                        mem_req.wr_en          = 1'b1;
                        mem_req.wr_addr        = '0;
                        mem_req.wr_char        = sym_data.symbol;
                        mem_req.wr_border      = '0;
                        last_border_next       = '0;
                        wpos_next              = kmppf_pkg::POS_W'(1);
                        res_next.border_length = '0;
                        res_next.char_position = '0;
                        res_next.overflow      = 1'b0;
                        state_next             = S_DONE;
                    end
                    else
                    begin
                        mem_req.rd_en          = 1'b1;
                        mem_req.char_rd_addr   = last_border_reg;
                        mem_req.border_rd_addr = last_border_reg - kmppf_pkg::ADDR_W'(1);
                        len_next               = last_border_reg;
                        state_next             = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (match || (len_reg == '0))
                begin
                    mem_req.wr_en          = 1'b1;
                    last_border_next       = fin_len;
                    wpos_next              = kmppf_pkg::POS_W'(p_reg) + kmppf_pkg::POS_W'(1);
                    res_next.border_length = kmppf_pkg::FIELD_W'(fin_len);
                    res_next.char_position = kmppf_pkg::FIELD_W'(p_reg);
                    res_next.overflow      = 1'b0;
                    state_next             = S_DONE;
                end
                else
                begin
                    // fall back to the next shorter border
                    mem_req.rd_en          = 1'b1;
                    mem_req.char_rd_addr   = border_rdata;
                    mem_req.border_rd_addr = border_rdata - kmppf_pkg::ADDR_W'(1);
                    len_next               = border_rdata;
                end
            end
            S_DONE:
            begin
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wpos_reg        <= '0;
            last_border_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            wpos_reg        <= wpos_next;
            last_border_reg <= last_border_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        p_reg   <= p_next;
        len_reg <= len_next;
        res_reg <= res_next;
    end

    `KMPPF_ASSERT_NOW(a_walk_below_pos, state_reg == S_WALK, len_reg < p_reg,
        "border walk candidate not below current position")
    `KMPPF_ASSERT_NEXT(a_write_then_done, mem_req.wr_en, state_reg == S_DONE,
        "store write not followed by a pending result")
    `KMPPF_ASSERT_NOW(a_wpos_range, 1'b1, wpos_reg <= POS_FULL,
        "write position beyond word capacity")

endmodule

FILE: rtl/kmp_prefix_function_stream.sv
// top level of the online kmp prefix function stream
// flow: a transaction is accepted only while idle; its result goes to a control result
//   register, then to the output register, after a border walk that reads each store once
//   per border tried (none for the first character or an overflow); no new transaction is
//   accepted until the last result has been taken into the output register
// reset: control state and write position clear at once; stores are not cleared
module kmp_prefix_function_stream (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_stall,
    input  kmppf_pkg::sym_item_t sym_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output kmppf_pkg::res_item_t res_data
);

    kmppf_pkg::mem_req_t               mem_req;
    logic [kmppf_pkg::SYM_W-1:0]       char_rdata;
    logic [kmppf_pkg::ADDR_W-1:0]      border_rdata;
    logic                              done_valid;
    logic                              done_take;
    kmppf_pkg::res_item_t              done_item;

    logic                              res_valid_reg, res_valid_next;
    kmppf_pkg::res_item_t              res_data_reg;

    kmppf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sym_valid    (sym_valid),
        .sym_stall    (sym_stall),
        .sym_data     (sym_data),
        .done_valid   (done_valid),
        .done_take    (done_take),
        .done_item    (done_item),
        .mem_req      (mem_req),
        .char_rdata   (char_rdata),
        .border_rdata (border_rdata)
    );

    kmppf_ram #(
        .WIDTH (kmppf_pkg::SYM_W),
        .DEPTH (kmppf_pkg::MAX_WORD_LEN),
        .AW    (kmppf_pkg::ADDR_W)
    ) u_char_store (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_char),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.char_rd_addr),
        .rd_data (char_rdata)
    );

    kmppf_ram #(
        .WIDTH (kmppf_pkg::ADDR_W),
        .DEPTH (kmppf_pkg::MAX_WORD_LEN),
        .AW    (kmppf_pkg::ADDR_W)
    ) u_border_store (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_border),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.border_rd_addr),
        .rd_data (border_rdata)
    );

    // output register
    assign done_take = done_valid && (!res_valid_reg || !res_stall);

    always_comb
    begin
        priority if (done_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            res_data_reg <= done_item;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
